### rtl/core/hrp_pkg.sv
// Shared types and constants for the HTTP response header parser.
package hrp_pkg;

    localparam int CODE_W = 10;
    localparam int LEN_W  = 31;
    localparam int OFF_W  = 13;
    localparam int TDATA_W = 64;

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam int LEAD_LEN    = 9;   // "HTTP/1.1 "
    localparam int PREFIX_END  = 12;  // prefix plus three digits
    localparam int MIN_MESSAGE = 13;
    localparam logic [3:0]        KEY_LEN   = 4'd14;
    localparam logic [CODE_W-1:0] CODE_OK   = 10'd200;
    localparam logic [LEN_W-1:0]  LEN_MAX   = 31'h7fffffff;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_STATUS = 3'd1,
        PH_KEY    = 3'd2,
        PH_SKIP   = 3'd3,
        PH_WS     = 3'd4,
        PH_DIGITS = 3'd5,
        PH_REST   = 3'd6,
        PH_STOP   = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        OUT_OK        = 2'd0,
        OUT_MALFORMED = 2'd1,
        OUT_OTHER     = 2'd2
    } outcome_t;

    typedef struct packed {
        logic                  header_complete;
        logic [OFF_W-1:0]      body_offset;
        logic [LEN_W-1:0]      content_length;
        logic [CODE_W-1:0]     status_code;
        outcome_t              outcome;
    } report_t;

endpackage

### rtl/core/hrp_parse_core.sv
// Parser state registers and the per-byte next-state and report logic.
module hrp_parse_core
    import hrp_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 4096
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output report_t    report
);

    localparam int PosW = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam logic [PosW:0] POS_MAX = (PosW + 1)'(MAX_MESSAGE_BYTES);

    typedef struct packed {
        phase_t           phase;
        logic [3:0]       kmc;
        logic [LEN_W-1:0] acc;
        logic             content;
        logic             neg;
    } line_t;

    function automatic logic [7:0] lead_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h48; // H
            4'd1:    ch = 8'h54; // T
            4'd2:    ch = 8'h54; // T
            4'd3:    ch = 8'h50; // P
            4'd4:    ch = 8'h2f; // /
            4'd5:    ch = 8'h31; // 1
            4'd6:    ch = 8'h2e; // .
            4'd7:    ch = 8'h31; // 1
            4'd8:    ch = 8'h20; // space
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6f; // o
            4'd2:    ch = 8'h6e; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6e; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2d; // -
            4'd8:    ch = 8'h4c; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6e; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // acc*10 + digit, saturating at 2^31-1
    function automatic logic [LEN_W-1:0] add_digit(input logic [LEN_W-1:0] acc,
                                                   input logic [7:0] c);
        logic [LEN_W+3:0] v;
        logic [7:0]       d;
        d = c - CHAR_ZERO;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (LEN_W + 4)'(d[3:0]);
        return (v > (LEN_W + 4)'(LEN_MAX)) ? LEN_MAX : v[LEN_W-1:0];
    endfunction

    function automatic line_t line_char(input line_t s, input logic [7:0] c);
        line_t n;
        n = s;
        n.content = 1'b1;
        case (s.phase)
            PH_KEY:
            begin
                if (c == CHAR_COLON)
                begin
                    n.phase = (s.kmc == KEY_LEN) ? PH_SKIP : PH_REST;
                end
                else if ((s.kmc < KEY_LEN) && (c == key_char(s.kmc)))
                begin
                    n.kmc = s.kmc + 4'd1;
                end
                else
                begin
                    n.phase = PH_REST;
                end
            end
            PH_SKIP:
            begin
                n.phase = PH_WS;
            end
            PH_WS:
            begin
                if (c inside {8'h20, [8'h09:8'h0d]})
                begin
                    n.phase = PH_WS;
                end
                else if (c == CHAR_PLUS)
                begin
                    n.phase = PH_DIGITS;
                end
                else if (c == CHAR_MINUS)
                begin
                    n.neg   = 1'b1;
                    n.phase = PH_DIGITS;
                end
                else if (is_digit(c))
                begin
                    n.acc   = add_digit(s.acc, c);
                    n.phase = PH_DIGITS;
                end
                else
                begin
                    n.phase = PH_REST;
                end
            end
            PH_DIGITS:
            begin
                if (is_digit(c))
                begin
                    n.acc = add_digit(s.acc, c);
                end
                else
                begin
                    n.phase = PH_REST;
                end
            end
            default:
            begin
                n.phase = s.phase;
            end
        endcase
        return n;
    endfunction

    phase_t            phase_reg, phase_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [PosW-1:0]   pos_reg, pos_next;
    logic [PosW-1:0]   begin_reg, begin_next;
    logic [3:0]        kmc_reg, kmc_next;
    logic [LEN_W-1:0]  acc_reg, acc_next;
    logic              content_reg, content_next;
    logic              neg_reg, neg_next;
    logic              malformed_reg, malformed_next;
    logic              cr_reg, cr_next;
    logic              done_reg, done_next;

    logic [PosW:0]        pos_inc;
    logic [PosW-1:0]      pos_sat;
    line_t                ln_cur, ln_a, ln_b;
    logic [7:0]           digit;
    logic [PosW+OFF_W-1:0] off_wide;

    always_comb
    begin
        pos_inc = {1'b0, pos_reg} + (PosW + 1)'(1);
        pos_sat = (pos_inc > POS_MAX) ? POS_MAX[PosW-1:0] : pos_inc[PosW-1:0];
        digit   = data_byte - CHAR_ZERO;

        phase_next     = phase_reg;
        code_next      = code_reg;
        len_next       = len_reg;
        begin_next     = begin_reg;
        kmc_next       = kmc_reg;
        acc_next       = acc_reg;
        content_next   = content_reg;
        neg_next       = neg_reg;
        malformed_next = malformed_reg;
        cr_next        = cr_reg;
        done_next      = done_reg;

        ln_cur = '{phase: phase_reg, kmc: kmc_reg, acc: acc_reg,
                   content: content_reg, neg: neg_reg};
        ln_a   = ln_cur;
        ln_b   = ln_cur;

        if (phase_reg == PH_PREFIX)
        begin
            if (pos_reg < PosW'(LEAD_LEN))
            begin
                if (data_byte != lead_char(pos_reg[3:0]))
                begin
                    malformed_next = 1'b1;
                    phase_next     = PH_STOP;
                end
            end
            else if (is_digit(data_byte))
            begin
                code_next = code_reg * CODE_W'(10) + CODE_W'(digit[3:0]);
                if (pos_reg == PosW'(PREFIX_END - 1))
                begin
                    phase_next = (code_next == CODE_OK) ? PH_STATUS : PH_STOP;
                end
            end
            else
            begin
                malformed_next = 1'b1;
                phase_next     = PH_STOP;
            end
        end
        else if (phase_reg != PH_STOP)
        begin
            if (cr_reg && (data_byte == CHAR_LF))
            begin
                cr_next    = 1'b0;
                begin_next = pos_sat;
                if ((phase_reg != PH_STATUS) && !content_reg)
                begin
                    // empty line: header ends here
                    done_next  = 1'b1;
                    phase_next = PH_STOP;
                end
                else
                begin
                    if ((phase_reg != PH_STATUS) && (acc_reg != '0) && !neg_reg)
                    begin
                        len_next = acc_reg;
                    end
                    phase_next   = PH_KEY;
                    kmc_next     = '0;
                    acc_next     = '0;
                    content_next = 1'b0;
                    neg_next     = 1'b0;
                end
            end
            else
            begin
                // a held CR that did not end a line counts as a line char
                if (cr_reg && (phase_reg != PH_STATUS))
                begin
                    ln_a = line_char(ln_cur, CHAR_CR);
                end
                ln_b = ln_a;
                if (data_byte == CHAR_CR)
                begin
                    cr_next = 1'b1;
                end
                else
                begin
                    cr_next = 1'b0;
                    if (phase_reg != PH_STATUS)
                    begin
                        ln_b = line_char(ln_a, data_byte);
                    end
                end
                phase_next   = ln_b.phase;
                kmc_next     = ln_b.kmc;
                acc_next     = ln_b.acc;
                content_next = ln_b.content;
                neg_next     = ln_b.neg;
            end
        end

        pos_next = pos_sat;

        off_wide = '0;
        report   = '0;
        if ((pos_next < PosW'(MIN_MESSAGE)) || (phase_next == PH_PREFIX) || malformed_next)
        begin
            report.outcome = OUT_MALFORMED;
        end
        else if (code_next != CODE_OK)
        begin
            report.outcome     = OUT_OTHER;
            report.status_code = code_next;
        end
        else
        begin
            report.outcome         = OUT_OK;
            report.status_code     = code_next;
            report.content_length  = len_next;
            off_wide = {{OFF_W{1'b0}}, ((phase_next == PH_STATUS) ? pos_next : begin_next)};
            report.body_offset     = off_wide[OFF_W-1:0];
            report.header_complete = done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PREFIX;
            code_reg      <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
            begin_reg     <= '0;
            kmc_reg       <= '0;
            acc_reg       <= '0;
            content_reg   <= 1'b0;
            neg_reg       <= 1'b0;
            malformed_reg <= 1'b0;
            cr_reg        <= 1'b0;
            done_reg      <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                // report taken at the marked byte; start the next message clean
                phase_reg     <= PH_PREFIX;
                code_reg      <= '0;
                len_reg       <= '0;
                pos_reg       <= '0;
                begin_reg     <= '0;
                kmc_reg       <= '0;
                acc_reg       <= '0;
                content_reg   <= 1'b0;
                neg_reg       <= 1'b0;
                malformed_reg <= 1'b0;
                cr_reg        <= 1'b0;
                done_reg      <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                code_reg      <= code_next;
                len_reg       <= len_next;
                pos_reg       <= pos_next;
                begin_reg     <= begin_next;
                kmc_reg       <= kmc_next;
                acc_reg       <= acc_next;
                content_reg   <= content_next;
                neg_reg       <= neg_next;
                malformed_reg <= malformed_next;
                cr_reg        <= cr_next;
                done_reg      <= done_next;
            end
        end
    end

endmodule

### rtl/core/http_response_header_parser_top.sv
// Top level of the HTTP response header parser: input word register, parser, report register.
//
//  Channel | Dir | Signals                         | Word carries
//  --------+-----+---------------------------------+------------------------------------------
//  s_*     | in  | s_tvalid s_tready s_tdata s_tlast | one response byte; tlast marks final byte
//  m_*     | out | m_tvalid m_tready m_tdata         | one report per message, at the final byte
//
//  One byte per cycle sustained. A byte is registered on entry, and the parser state
//  plus the report are updated from that register, so m_tvalid rises once the final
//  byte has moved from the input register into the report register.
//  Reset (rst_n low, asynchronous) empties both registers and clears the parser.
//  A stalled report only holds back a final byte; ordinary bytes keep flowing while
//  the report register waits on m_tready.
module http_response_header_parser_top
    import hrp_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // last_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // [1:0] outcome, [11:2] status_code,
                                          // [42:12] content_length,
                                          // [55:43] body_offset, [56] header_complete
);

    logic       in_vld_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       out_vld_reg;
    report_t    out_rpt_reg;
    report_t    rpt;
    logic       out_free;
    logic       step;
    logic       s_fire;

    // a word moves into the parser unless it is a final byte that has nowhere to go
    assign out_free = !out_vld_reg || m_tready;
    assign step     = in_vld_reg && (!in_last_reg || out_free);
    assign s_tready = !in_vld_reg || step;
    assign s_fire   = s_tvalid && s_tready;

    hrp_parse_core #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .report    (rpt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= s_fire || (in_vld_reg && !step);
            if (step && in_last_reg)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (step && in_last_reg)
        begin
            out_rpt_reg <= rpt;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(TDATA_W - $bits(report_t)){1'b0}}, out_rpt_reg};

    // a final byte waiting on a full, stalled report register must stay put
    a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && in_last_reg && out_vld_reg && !m_tready)
            |=> (in_vld_reg && in_last_reg))
        else $error("final byte lost while report stalled");

    // malformed reports carry no code, length, offset or header flag
    a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] == OUT_MALFORMED)) |-> (m_tdata[56:2] == '0))
        else $error("malformed report with nonzero fields");

    // other-status reports carry only the code
    a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] == OUT_OTHER)) |-> (m_tdata[56:12] == '0))
        else $error("other-status report with nonzero length or offset");

    // a report is only loaded by a final byte leaving the input register
    a_report_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_vld_reg && !(step && in_last_reg)) |=> !out_vld_reg)
        else $error("report appeared without a final byte");

endmodule

### bench/hrp_report_checker.sv
// Report checker for the HTTP response header parser: predicts each report and compares it.
module hrp_report_checker
    import hrp_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] data_byte
    input  logic               s_tlast,    // last_byte
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,    // report_t in the low bits, zero padding above
    output int                 fail_count,
    output int                 pending
);

    localparam int REPORT_W = $bits(report_t);
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [8*LEAD_LEN-1:0]      LEAD_TEXT = "HTTP/1.1 ";
    localparam logic [8*int'(KEY_LEN)-1:0] KEY_TEXT  = "Content-Length";

    report_t            expected_reports[$];

    // parser state of the prediction
    int                 byte_pos;
    phase_t             phase;
    logic [CODE_W-1:0]  code;
    logic [LEN_W-1:0]   kept_len;
    int                 line_begin;
    logic [3:0]         key_cnt;
    logic [31:0]        accum;
    logic               has_content;
    logic               neg_seen;
    logic               malformed;
    logic               cr_pend;
    logic               hdr_done;

    function automatic int sat_pos(int p);
        return (p > MAX_MESSAGE_BYTES) ? MAX_MESSAGE_BYTES : p;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_ZERO + 8'd9;
    endfunction

    task automatic clear_parse();
        byte_pos    = 0;
        phase       = PH_PREFIX;
        code        = '0;
        kept_len    = '0;
        line_begin  = 0;
        key_cnt     = '0;
        accum       = '0;
        has_content = 1'b0;
        neg_seen    = 1'b0;
        malformed   = 1'b0;
        cr_pend     = 1'b0;
        hdr_done    = 1'b0;
    endtask

    task automatic start_line();
        phase       = PH_KEY;
        key_cnt     = '0;
        accum       = '0;
        has_content = 1'b0;
        neg_seen    = 1'b0;
    endtask

    task automatic add_digit(logic [7:0] c);
        longint unsigned v;
        v = longint'(accum) * 10 + longint'(c - CHAR_ZERO);
        accum = (v > LEN_MAX) ? 32'(LEN_MAX) : v[31:0];
    endtask

    // one character of a header line
    task automatic header_char(logic [7:0] c);
        has_content = 1'b1;
        case (phase)
            PH_KEY:
            begin
                if (c == CHAR_COLON)
                    phase = (key_cnt == KEY_LEN) ? PH_SKIP : PH_REST;
                else if (key_cnt < KEY_LEN &&
                         c == KEY_TEXT[8*(int'(KEY_LEN)-1-int'(key_cnt)) +: 8])
                    key_cnt++;
                else
                    phase = PH_REST;
            end
            PH_SKIP:
                phase = PH_WS;
            PH_WS:
            begin
                if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
                    phase = PH_WS;
                else if (c == CHAR_PLUS)
                    phase = PH_DIGITS;
                else if (c == CHAR_MINUS)
                begin
                    neg_seen = 1'b1;
                    phase    = PH_DIGITS;
                end
                else if (is_digit(c))
                begin
                    add_digit(c);
                    phase = PH_DIGITS;
                end
                else
                    phase = PH_REST;
            end
            PH_DIGITS:
            begin
                if (is_digit(c))
                    add_digit(c);
                else
                    phase = PH_REST;
            end
            default: ;
        endcase
    endtask

    task automatic parse_byte(logic [7:0] c, logic fin);
        report_t r;
        if (phase == PH_PREFIX)
        begin
            if (byte_pos < LEAD_LEN)
            begin
                if (c != LEAD_TEXT[8*(LEAD_LEN-1-byte_pos) +: 8])
                begin
                    malformed = 1'b1;
                    phase     = PH_STOP;
                end
            end
            else if (is_digit(c))
            begin
                code = CODE_W'(code * 10 + (c - CHAR_ZERO));
                if (byte_pos + 1 == PREFIX_END)
                    phase = (code == CODE_OK) ? PH_STATUS : PH_STOP;
            end
            else
            begin
                malformed = 1'b1;
                phase     = PH_STOP;
            end
        end
        else if (phase != PH_STOP)
        begin
            if (cr_pend && c == CHAR_LF)
            begin
                cr_pend    = 1'b0;
                line_begin = sat_pos(byte_pos + 1);
                if (phase == PH_STATUS)
                    start_line();
                else if (!has_content)
                begin
                    hdr_done = 1'b1;
                    phase    = PH_STOP;
                end
                else
                begin
                    if (accum != 0 && !neg_seen)
                        kept_len = accum[LEN_W-1:0];
                    start_line();
                end
            end
            else
            begin
                // a CR not followed by LF is an ordinary character
                if (cr_pend && phase != PH_STATUS)
                    header_char(CHAR_CR);
                if (c == CHAR_CR)
                    cr_pend = 1'b1;
                else
                begin
                    cr_pend = 1'b0;
                    if (phase != PH_STATUS)
                        header_char(c);
                end
            end
        end

        byte_pos = sat_pos(byte_pos + 1);

        if (fin)
        begin
            r = '0;
            if (byte_pos < MIN_MESSAGE || phase == PH_PREFIX || malformed)
                r.outcome = OUT_MALFORMED;
            else if (code != CODE_OK)
            begin
                r.outcome     = OUT_OTHER;
                r.status_code = code;
            end
            else
            begin
                r.outcome         = OUT_OK;
                r.status_code     = code;
                r.content_length  = kept_len;
                r.body_offset     = OFF_W'((phase == PH_STATUS) ? byte_pos : line_begin);
                r.header_complete = hdr_done;
            end
            expected_reports.push_back(r);
            clear_parse();
        end
    endtask

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            if (fail_count < 10)
                $display("checker: %s mismatch, expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        report_t got;
        report_t want;
        if (!rst_n)
        begin
            clear_parse();
            expected_reports.delete();
            pending <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[REPORT_W-1:0];
                if (expected_reports.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("checker: report word with nothing expected, data %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("outcome", want.outcome, got.outcome);
                    compare_field("status_code", want.status_code, got.status_code);
                    compare_field("content_length", want.content_length, got.content_length);
                    compare_field("body_offset", want.body_offset, got.body_offset);
                    compare_field("header_complete", want.header_complete, got.header_complete);
                    compare_field("padding", 0, m_tdata[TDATA_W-1:REPORT_W]);
                end
            end
            pending <= expected_reports.size();
        end
    end

endmodule

### bench/tb_top.sv
// Testbench top for the HTTP response header parser: stimulus, flow control and verdict.
module tb_top;
    import hrp_pkg::*;

    localparam int MAX_BYTES    = 4096;
    localparam int RANDOM_BYTES = 850;   // random stimulus stops after this many bytes
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int LONG_FILL    = 150;   // one long header line
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 34;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0b;
    localparam logic [7:0] CHAR_FF    = 8'h0c;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = 8'h00;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    int                 fail_count;
    int                 pending;

    logic [7:0]         msg_q[$];        // bytes of the response being built
    int                 random_sent;
    bit                 s_idle_on = 1'b1;
    bit                 m_idle_on = 1'b1;
    bit                 hold_req  = 1'b0;

    http_response_header_parser_top #(
        .MAX_MESSAGE_BYTES (MAX_BYTES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hrp_report_checker #(
        .MAX_MESSAGE_BYTES (MAX_BYTES)
    ) report_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // Report side: random stalls, or one long hold-off when the sender asks for it.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= !m_idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ---------------------------------------------------------------- response text

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            msg_q.push_back(s[i]);
    endfunction

    function automatic void add_eol();
        msg_q.push_back(CHAR_CR);
        msg_q.push_back(CHAR_LF);
    endfunction

    // One header line: often Content-Length with assorted values, plus near misses,
    // ordinary headers and raw bytes.
    function automatic void add_header_line();
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                add_text("Content-Length:");
                // the byte right after the colon is skipped, whatever it is
                if ($urandom_range(3) != 0)
                    msg_q.push_back(CHAR_SPACE);
                else
                    msg_q.push_back(8'($urandom_range(255)));
                repeat ($urandom_range(2))
                begin
                    case ($urandom_range(4))
                        0:       msg_q.push_back(CHAR_SPACE);
                        1:       msg_q.push_back(CHAR_TAB);
                        2:       msg_q.push_back(CHAR_VT);
                        3:       msg_q.push_back(CHAR_FF);
                        default: msg_q.push_back(CHAR_LF);
                    endcase
                end
                case ($urandom_range(5))
                    0:       msg_q.push_back(CHAR_PLUS);
                    1:       msg_q.push_back(CHAR_MINUS);
                    default: ;
                endcase
                case ($urandom_range(6))
                    0:       add_text("0");
                    1:       add_text("2147483647");
                    2:       add_text("2147483648");
                    3:       add_text($sformatf("%0d%06d", $urandom_range(999999, 1),
                                                $urandom_range(999999)));
                    4:       add_text($sformatf("00%0d", $urandom_range(99)));
                    default: add_text($sformatf("%0d", $urandom_range(99999)));
                endcase
                if ($urandom_range(3) == 0)
                    add_text(" ;q");
            end
            4:
                add_text("Content-Length:");           // line ends at the colon
            5:
            begin
                case ($urandom_range(5))
                    0:       add_text("Content-Lengt: 5");
                    1:       add_text("Content-Lengthh: 7");
                    2:       add_text("content-length: 9");
                    3:       add_text("Content-Length : 3");
                    4:       add_text("XContent-Length: 4");
                    default: add_text("Content-Length");
                endcase
            end
            6, 7:
            begin
                add_text("Server: ");
                repeat ($urandom_range(6))
                    msg_q.push_back(8'($urandom_range(126, 32)));
            end
            8:
            begin
                repeat ($urandom_range(6, 1))
                    msg_q.push_back(8'($urandom_range(255)));
            end
            default:
                add_text(": 12");
        endcase
        add_eol();
    endfunction

    function automatic void build_message();
        int kind;
        int cut;
        msg_q.delete();
        kind = $urandom_range(19);
        if (kind <= 11)
        begin
            // status 200, mostly well formed
            add_text("HTTP/1.1 200");
            if ($urandom_range(15) == 0)
            begin
                // status line never terminated
                repeat ($urandom_range(5))
                    msg_q.push_back(8'($urandom_range(126, 32)));
            end
            else
            begin
                if ($urandom_range(1) == 1)
                    add_text(" OK");
                add_eol();
                repeat ($urandom_range(4))
                    add_header_line();
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5, 6:
                    begin
                        add_eol();
                        // body bytes are ignored by the parser
                        repeat ($urandom_range(6))
                            msg_q.push_back(8'($urandom_range(255)));
                    end
                    7:       add_text("Content-Length: 12");   // unfinished last line
                    8:       msg_q.push_back(CHAR_CR);          // CR as the final byte
                    default: ;
                endcase
            end
        end
        else if (kind <= 14)
        begin
            // other status code
            add_text("HTTP/1.1 ");
            repeat (3)
                msg_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
            add_text(" X");
            add_eol();
            repeat ($urandom_range(2))
                add_header_line();
            add_eol();
        end
        else if (kind <= 17)
        begin
            add_text("HTTP/1.1 200 OK");
            add_eol();
            if ($urandom_range(1) == 1)
            begin
                // damage one byte of the status prefix
                add_text("Content-Length: 5");
                add_eol();
                add_eol();
                msg_q[$urandom_range(PREFIX_END - 1)] = 8'($urandom_range(255));
            end
            else
            begin
                // truncated around the minimum length
                cut = $urandom_range(MIN_MESSAGE + 1, 1);
                while (msg_q.size() > cut)
                    void'(msg_q.pop_back());
            end
        end
        else
        begin
            repeat ($urandom_range(20, 1))
                msg_q.push_back(8'($urandom_range(255)));
        end
    endfunction

    // ---------------------------------------------------------------- driving

    // Offer one word and hold it until accepted; random gaps go in front of it.
    task automatic send_byte(logic [7:0] b, logic fin);
        while (s_idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_message();
        foreach (msg_q[i])
            send_byte(msg_q[i], i == msg_q.size() - 1);
    endtask

    task automatic send_random(int stop_at);
        while (random_sent < stop_at)
        begin
            build_message();
            send_message();
            random_sent += msg_q.size();
        end
    endtask

    // Stop offering, then wait until every predicted report has been seen.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        random_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single all-ones word: too short
        msg_q.delete();
        msg_q.push_back(8'hff);
        send_message();
        // minimum length, other status, zero byte as an ordinary character
        msg_q.delete();
        add_text("HTTP/1.1 404");
        msg_q.push_back(8'h00);
        send_message();
        // final CR leaves the status line open
        msg_q.delete();
        add_text("HTTP/1.1 200");
        msg_q.push_back(CHAR_CR);
        send_message();

        send_random(300);

        // receiver holds off while short messages keep coming, so the input stalls
        hold_req = 1'b1;
        repeat (6)
        begin
            msg_q.delete();
            msg_q.push_back(8'($urandom_range(255)));
            send_message();
        end

        // sender pause, then one message with a long header line
        drain();
        msg_q.delete();
        add_text("HTTP/1.1 200 OK");
        add_eol();
        add_text("X-Fill: ");
        repeat (LONG_FILL)
            msg_q.push_back(8'($urandom_range(126, 32)));
        add_eol();
        add_text("Content-Length: 9");
        add_eol();
        add_eol();
        send_message();
        drain();

        // long stretch with no idling on either side
        s_idle_on = 1'b0;
        m_idle_on = 1'b0;
        send_random(600);

        s_idle_on = 1'b1;
        m_idle_on = 1'b1;
        send_random(RANDOM_BYTES);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
